/* hdl/mnn_pkg.sv */
// Shared constants for the mixed number normaliser and its checker.
package mnn_pkg;

    // Width of every result field.
    localparam int OUT_WIDTH = 32;

    // Encodings of the mode register.
    localparam logic MODE_MIXED    = 1'b0;
    localparam logic MODE_IMPROPER = 1'b1;

endpackage

/* hdl/mixed_number_normalizer.sv */
// Mixed number normaliser: Euclidean fraction reduction on a bit-serial shared divider.
// Steps in order: accept, multiply (improper mode only), set-up, then for each Euclid
// iteration a GCD state and a division, a GCD state that sees the zero remainder, the final
// divisions (two, and a third for a non-negative non-zero mixed fraction) and the load of the
// output register; a zero denominator skips to the output load. One item is in work at a
// time. Reset (rst_n low, asynchronous) clears the mode to mixed and empties the output.
module mixed_number_normalizer #(
    parameter int IN_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Mode register write port.
    input  logic                                   mode_we,
    input  logic                                   mode_wdata,
    // Input beat.
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [IN_WIDTH-1:0]             whole_in,
    input  logic signed [IN_WIDTH-1:0]             numer_in,
    input  logic signed [IN_WIDTH-1:0]             denom_in,
    // Result beat.
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [mnn_pkg::OUT_WIDTH-1:0]   whole_out,
    output logic signed [mnn_pkg::OUT_WIDTH-1:0]   numer_out,
    output logic signed [mnn_pkg::OUT_WIDTH-1:0]   denom_out,
    output logic                                   div_error
);
    import mnn_pkg::*;

    // The improper numerator n + d*w needs twice the input width; every magnitude that
    // passes through the divider fits in that width.
    localparam int MW = 2 * IN_WIDTH;
    // Working width for the final sign and wrap to the output width.
    localparam int XW = (MW > OUT_WIDTH) ? MW : OUT_WIDTH;
    localparam int CW = $clog2(MW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_GCD,
        S_DIV,
        S_OUT
    } state_t;

    // What the divider is working on, so that its result goes to the right place.
    typedef enum logic [1:0] {
        PH_GCD,
        PH_RN,
        PH_RD,
        PH_WH
    } phase_t;

    state_t                state_reg;
    phase_t                phase_reg;
    logic                  mode_reg;

    // Captured operands.
    logic [IN_WIDTH-1:0]   w_reg;
    logic [IN_WIDTH-1:0]   n_reg;
    logic [IN_WIDTH-1:0]   d_reg;
    logic                  err_reg;

    // Shift-and-add multiplier for |d| * |w|.
    logic [MW-1:0]         acc_reg;
    logic [MW-1:0]         mcand_reg;
    logic [IN_WIDTH-1:0]   mplier_reg;

    // Fraction being reduced.
    logic [MW-1:0]         mn_reg;
    logic [MW-1:0]         md_reg;
    logic                  neg_reg;
    logic [OUT_WIDTH-1:0]  ws_reg;

    // Euclid operands.
    logic [MW-1:0]         x_reg;
    logic [MW-1:0]         y_reg;

    // Restoring divider: dq_reg shifts the dividend out and the quotient in.
    logic [MW-1:0]         dq_reg;
    logic [MW-1:0]         rem_reg;
    logic [MW-1:0]         dv_reg;
    logic [CW-1:0]         cnt_reg;

    logic                  out_valid_reg;
    logic [OUT_WIDTH-1:0]  whole_out_reg;
    logic [OUT_WIDTH-1:0]  numer_out_reg;
    logic [OUT_WIDTH-1:0]  denom_out_reg;
    logic                  div_error_reg;

    // Combinational helpers.
    logic [IN_WIDTH-1:0]   in_w_mag;
    logic [IN_WIDTH-1:0]   in_d_mag;
    logic [IN_WIDTH-1:0]   d_mag;
    logic                  prod_neg;
    logic [MW-1:0]         prod;
    logic [MW-1:0]         t_val;
    logic [MW-1:0]         t_mag;
    logic [MW:0]           div_shift;
    logic [MW:0]           div_diff;
    logic                  div_ge;
    logic [MW-1:0]         rem_next;
    logic [MW-1:0]         q_next;
    logic [XW-1:0]         q_ext;
    logic [XW-1:0]         mn_ext;
    logic [XW-1:0]         numer_signed;
    logic [XW-1:0]         md_ext;
    logic                  in_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign whole_out = whole_out_reg;
    assign numer_out = numer_out_reg;
    assign denom_out = denom_out_reg;
    assign div_error = div_error_reg;

    always_comb
    begin
        // Magnitudes of the incoming beat, used to load the multiplier.
        in_w_mag = whole_in[IN_WIDTH-1] ? ({IN_WIDTH{1'b0}} - whole_in) : whole_in;
        in_d_mag = denom_in[IN_WIDTH-1] ? ({IN_WIDTH{1'b0}} - denom_in) : denom_in;
        d_mag    = d_reg[IN_WIDTH-1] ? ({IN_WIDTH{1'b0}} - d_reg) : d_reg;

        // In mixed mode the accumulator stays zero, so t is just the numerator.
        prod_neg = w_reg[IN_WIDTH-1] ^ d_reg[IN_WIDTH-1];
        prod     = prod_neg ? ({MW{1'b0}} - acc_reg) : acc_reg;
        t_val    = MW'(signed'(n_reg)) + prod;
        t_mag    = t_val[MW-1] ? ({MW{1'b0}} - t_val) : t_val;

        // One restoring division step.
        div_shift = {rem_reg, dq_reg[MW-1]};
        div_diff  = div_shift - {1'b0, dv_reg};
        div_ge    = !div_diff[MW];
        rem_next  = div_ge ? div_diff[MW-1:0] : div_shift[MW-1:0];
        q_next    = {dq_reg[MW-2:0], div_ge};

        q_ext        = XW'(q_next);
        mn_ext       = XW'(mn_reg);
        md_ext       = XW'(md_reg);
        numer_signed = neg_reg ? ({XW{1'b0}} - mn_ext) : mn_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_GCD;
            mode_reg      <= MODE_MIXED;
            w_reg         <= '0;
            n_reg         <= '0;
            d_reg         <= '0;
            err_reg       <= 1'b0;
            acc_reg       <= '0;
            mcand_reg     <= '0;
            mplier_reg    <= '0;
            mn_reg        <= '0;
            md_reg        <= '0;
            neg_reg       <= 1'b0;
            ws_reg        <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            dq_reg        <= '0;
            rem_reg       <= '0;
            dv_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            whole_out_reg <= '0;
            numer_out_reg <= '0;
            denom_out_reg <= '0;
            div_error_reg <= 1'b0;
        end
        else
        begin
            if (mode_we)
            begin
                mode_reg <= mode_wdata;
            end

            // The output register empties when its beat is taken; a load below overrides.
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        w_reg      <= whole_in;
                        n_reg      <= numer_in;
                        d_reg      <= denom_in;
                        acc_reg    <= '0;
                        mcand_reg  <= MW'(in_d_mag);
                        mplier_reg <= in_w_mag;
                        cnt_reg    <= '0;
                        if (denom_in == '0)
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            err_reg   <= 1'b0;
                            state_reg <= (mode_reg == MODE_IMPROPER) ? S_MUL : S_PREP;
                        end
                    end
                end

                S_MUL:
                begin
                    if (mplier_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[MW-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[IN_WIDTH-1:1]};
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(IN_WIDTH - 1))
                    begin
                        state_reg <= S_PREP;
                    end
                end

                S_PREP:
                begin
                    neg_reg   <= t_val[MW-1] != d_reg[IN_WIDTH-1];
                    mn_reg    <= t_mag;
                    md_reg    <= MW'(d_mag);
                    x_reg     <= MW'(d_mag);
                    y_reg     <= t_mag;
                    ws_reg    <= (mode_reg == MODE_IMPROPER) ? '0 : OUT_WIDTH'(signed'(w_reg));
                    state_reg <= S_GCD;
                end

                S_GCD:
                begin
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                    if (y_reg == '0)
                    begin
                        // x holds the divisor; the numerator is divided first.
                        dq_reg    <= mn_reg;
                        dv_reg    <= x_reg;
                        phase_reg <= PH_RN;
                    end
                    else
                    begin
                        dq_reg    <= x_reg;
                        dv_reg    <= y_reg;
                        phase_reg <= PH_GCD;
                    end
                end

                S_DIV:
                begin
                    rem_reg <= rem_next;
                    dq_reg  <= q_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(MW - 1))
                    begin
                        case (phase_reg)
                            PH_GCD:
                            begin
                                x_reg     <= y_reg;
                                y_reg     <= rem_next;
                                state_reg <= S_GCD;
                            end
                            PH_RN:
                            begin
                                // Same divisor again, now for the denominator.
                                mn_reg    <= q_next;
                                dq_reg    <= md_reg;
                                rem_reg   <= '0;
                                cnt_reg   <= '0;
                                phase_reg <= PH_RD;
                            end
                            PH_RD:
                            begin
                                md_reg  <= q_next;
                                neg_reg <= neg_reg && (mn_reg != '0);
                                if (mode_reg == MODE_MIXED && !neg_reg && mn_reg != '0)
                                begin
                                    // A quotient of zero leaves the whole part as it is.
                                    dq_reg    <= mn_reg;
                                    dv_reg    <= q_next;
                                    rem_reg   <= '0;
                                    cnt_reg   <= '0;
                                    phase_reg <= PH_WH;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            PH_WH:
                            begin
                                ws_reg    <= ws_reg + q_ext[OUT_WIDTH-1:0];
                                mn_reg    <= rem_next;
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        div_error_reg <= err_reg;
                        state_reg     <= S_IDLE;
                        if (err_reg)
                        begin
                            whole_out_reg <= OUT_WIDTH'(signed'(w_reg));
                            numer_out_reg <= OUT_WIDTH'(signed'(n_reg));
                            denom_out_reg <= '0;
                        end
                        else
                        begin
                            whole_out_reg <= ws_reg;
                            numer_out_reg <= numer_signed[OUT_WIDTH-1:0];
                            denom_out_reg <= md_ext[OUT_WIDTH-1:0];
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/mnn_checker.sv */
// Port-level checks for the mixed number normaliser, bound to its top level.
module mnn_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [mnn_pkg::OUT_WIDTH-1:0] whole_out,
    input  logic signed [mnn_pkg::OUT_WIDTH-1:0] numer_out,
    input  logic signed [mnn_pkg::OUT_WIDTH-1:0] denom_out,
    input  logic                                 div_error
);
    import mnn_pkg::*;

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(whole_out) && $stable(numer_out)
            && $stable(denom_out) && $stable(div_error))
        else $error("result beat changed while stalled");

    // One item at a time: the input side closes after each accepted beat.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in work");

    // An error result carries a zero denominator, a normal one never does.
    a_err_denom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (div_error == (denom_out == '0)))
        else $error("denominator does not match the error flag");

    // A zero fraction is always reported as 0/1.
    a_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !div_error && numer_out == '0 |-> denom_out == OUT_WIDTH'(1))
        else $error("zero fraction not reduced to 0/1");

endmodule

bind mixed_number_normalizer mnn_checker u_mnn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .whole_out (whole_out),
    .numer_out (numer_out),
    .denom_out (denom_out),
    .div_error (div_error)
);
